/* hw/rtl/kol_pkg.sv */
// Package for the k-mer occurrence locator: widths, types and register indexes.
// No dependencies.
`default_nettype none
package kol_pkg;
  localparam int MAX_KMER = 16;
  localparam int POS_BITS = 28;
  localparam int WIN_BITS = 2 * MAX_KMER;
  localparam int KLEN_BITS = 5;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KMER_LENGTH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_SIZE = 2'd2;

  typedef struct packed {
    logic [7:0]          chrom;
    logic                strand;
    logic [POS_BITS-1:0] position;
  } hit_t;

  typedef struct packed {
    logic [7:0]          match_chrom;
    logic                match_strand;
    logic [POS_BITS-1:0] match_position;
    logic [POS_BITS-1:0] bin_start;
  } result_t;

  typedef struct packed {
    logic [2:0]          base;
    logic                seq_start;
    logic                strand;
    logic [7:0]          chrom_id;
    logic [POS_BITS-1:0] chrom_length;
  } base_t;
endpackage
`default_nettype wire

/* hw/rtl/kol_if.sv */
// Valid/ready channel interface carrying one word of a given struct type.
// Depends on kol_pkg for the payload types.
`default_nettype none
interface kol_base_if import kol_pkg::*; ();
  logic  valid;
  logic  ready;
  base_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kol_result_if import kol_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/kol_front.sv */
// Front end: shifts bases into the window, detects matches, mirrors positions.
// Depends on kol_pkg.
`default_nettype none
module kol_front import kol_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire base_t               item,
  input  wire logic [WIN_BITS-1:0] pattern,
  input  wire logic [KLEN_BITS-1:0] kmer_length,
  output logic                     hit_valid,
  output hit_t                     hit
);
  logic [WIN_BITS-1:0] win_r, win_nxt, win_src;
  logic [KLEN_BITS-1:0] run_r, run_nxt;
  logic [POS_BITS-1:0] idx_r, idx_nxt, here, first;
  logic [KLEN_BITS-1:0] k;
  logic [WIN_BITS-1:0] mask, aligned;
  logic [POS_BITS:0] sub;
  logic match;

  always_comb begin
    if (kmer_length == '0) k = KLEN_BITS'(1);
    else if (kmer_length > KLEN_BITS'(MAX_KMER)) k = KLEN_BITS'(MAX_KMER);
    else k = kmer_length;
    here = item.seq_start ? '0 : idx_r;
    idx_nxt = here + POS_BITS'(1);
    win_src = item.seq_start ? '0 : win_r;
    win_nxt = {item.base[1:0], win_src[WIN_BITS-1:2]};
    if (item.base[2]) run_nxt = '0;
    else begin
      run_nxt = item.seq_start ? '0 : run_r;
      if (run_nxt < KLEN_BITS'(MAX_KMER)) run_nxt = run_nxt + KLEN_BITS'(1);
    end
    mask = (WIN_BITS'(1) << (2 * k)) - WIN_BITS'(1);
    if (k == KLEN_BITS'(MAX_KMER)) mask = '1;
    aligned = win_nxt >> (WIN_BITS - 2 * k);
    match = !item.base[2] && (run_nxt >= k) && ((aligned & mask) == (pattern & mask));
    first = here - POS_BITS'(k - KLEN_BITS'(1));
    sub = {1'b0, first} + (POS_BITS+1)'(k);
    hit_valid = take && match;
    hit.chrom = item.chrom_id;
    hit.strand = item.strand;
    if (item.strand)
      hit.position = ({1'b0, item.chrom_length} > sub) ?
                     item.chrom_length - sub[POS_BITS-1:0] : '0;
    else hit.position = first;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      run_r <= '0;
      idx_r <= '0;
    end else if (take) begin
      win_r <= win_nxt;
      run_r <= run_nxt;
      idx_r <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_run_sat: assert property (@(posedge clk) disable iff (!rst_n)
    run_r <= KLEN_BITS'(MAX_KMER)) else $error("valid run beyond saturation");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    take && !item.seq_start |=> idx_r == $past(idx_r) + POS_BITS'(1))
    else $error("position counter skipped");
  a_hit_take: assert property (@(posedge clk) disable iff (!rst_n)
    hit_valid |-> take) else $error("hit without base");
`endif
endmodule
`default_nettype wire

/* hw/rtl/kol_queue.sv */
// Short FIFO of hits between the front end and the binning back end.
// Depends on kol_pkg.
`default_nettype none
module kol_queue import kol_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire hit_t push_data,
  input  wire logic pop,
  output logic      full,
  output logic      empty,
  output hit_t      head
);
  hit_t mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wp_r, rp_r;
  logic [QPTR_BITS:0] cnt_r;

  assign full = cnt_r == (QPTR_BITS+1)'(QDEPTH);
  assign empty = cnt_r == '0;
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + QPTR_BITS'(1);
      if (pop) rp_r <= rp_r + QPTR_BITS'(1);
      cnt_r <= cnt_r + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty queue");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_BITS+1)'(QDEPTH)) else $error("queue count overflow");
`endif
endmodule
`default_nettype wire

/* hw/rtl/kol_binner.sv */
// Back end: restoring divider that rounds a position down to a bin multiple.
// One quotient bit per cycle, then a multiply state. Depends on kol_pkg.
`default_nettype none
module kol_binner import kol_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire hit_t                hit,
  input  wire logic [POS_BITS-1:0] bin_size,
  output logic                     busy,
  kol_result_if.source             out
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_DIV = 4'b0010, S_MUL = 4'b0100, S_OUT = 4'b1000
  } state_t;
  localparam int CNT_BITS = $clog2(POS_BITS + 1);

  state_t st_r, st_nxt;
  hit_t hit_r;
  logic [POS_BITS-1:0] bs_r, quo_r, rem_r, res_r;
  logic [POS_BITS:0] trial;
  logic [CNT_BITS-1:0] cnt_r;
  logic [2*POS_BITS-1:0] prod;

  assign trial = {rem_r, hit_r.position[cnt_r[CNT_BITS-1:0] - CNT_BITS'(1)]};
  assign prod = quo_r * bs_r;
  assign busy = st_r != S_IDLE;
  assign out.valid = st_r == S_OUT;
  assign out.data = '{match_chrom: hit_r.chrom, match_strand: hit_r.strand,
                      match_position: hit_r.position, bin_start: res_r};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (start) st_nxt = S_DIV;
      S_DIV:  if (cnt_r == CNT_BITS'(1)) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_OUT;
      S_OUT:  if (out.ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        hit_r <= hit;
        bs_r <= (bin_size == '0) ? POS_BITS'(1) : bin_size;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CNT_BITS'(POS_BITS);
      end
      S_DIV: begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (trial >= {1'b0, bs_r}) begin
          rem_r <= trial[POS_BITS-1:0] - bs_r;
          quo_r <= {quo_r[POS_BITS-2:0], 1'b1};
        end else begin
          rem_r <= trial[POS_BITS-1:0];
          quo_r <= {quo_r[POS_BITS-2:0], 1'b0};
        end
      end
      S_MUL: res_r <= prod[POS_BITS-1:0];
      S_OUT: ;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == S_IDLE) else $error("start while busy");
  a_bin_le: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid |-> out.data.bin_start <= out.data.match_position)
    else $error("bin start beyond position");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid && !out.ready |=> out.valid && $stable(out.data))
    else $error("result word changed while stalled");
`endif
endmodule
`default_nettype wire

/* hw/rtl/kmer_occurrence_locator.sv */
// Top level of the k-mer occurrence locator: registers, front end, hit queue
// and binning back end. Depends on kol_pkg, kol_if, kol_front, kol_queue, kol_binner.
//
// Usage: bases arrive as words on the in_ channel (valid/ready). The front end
// takes one base per cycle, tracks the window, the valid run and the position,
// and on a match pushes a hit into a four-entry queue. A base is refused only
// when that queue is full. The back end pops one hit at a time, divides its
// position by the bin size with a restoring divider (one quotient bit per
// cycle), multiplies back and offers the result word on the out_ channel
// from its output register. Matches can be taken at one per cycle in bursts
// of up to five (four in the queue and one in the divider); the back end pops
// a new hit only after the result word of the last one has been taken, so
// the divider sets the sustained hit rate. A stall on the out_ channel holds
// the result word; bases keep flowing until the queue fills. Synchronous
// active-low reset clears the window, run, position, queue and registers
// (pattern 0, k-mer length 8, bin size 20000). The user must write
// configuration through cfg_ only while the block is idle; the block itself
// does not enforce it.
`default_nettype none
module kmer_occurrence_locator import kol_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  kol_base_if.sink                      in_ch,
  kol_result_if.source                  out_ch
);
  logic [WIN_BITS-1:0] pattern_r;
  logic [KLEN_BITS-1:0] klen_r;
  logic [POS_BITS-1:0] bin_r;
  logic take, hit_valid, full, empty, busy, pop;
  hit_t hit, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      klen_r <= KLEN_BITS'(8);
      bin_r <= POS_BITS'(20000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN:     pattern_r <= cfg_data[WIN_BITS-1:0];
        REG_KMER_LENGTH: klen_r <= cfg_data[KLEN_BITS-1:0];
        REG_BIN_SIZE:    bin_r <= cfg_data[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !full;
  assign take = in_ch.valid && !full;
  assign pop = !empty && !busy;

  kol_front u_front (.clk, .rst_n, .take, .item(in_ch.data), .pattern(pattern_r),
                     .kmer_length(klen_r), .hit_valid, .hit);
  kol_queue u_queue (.clk, .rst_n, .push(hit_valid), .push_data(hit), .pop,
                     .full, .empty, .head);
  kol_binner u_binner (.clk, .rst_n, .start(pop), .hit(head), .bin_size(bin_r),
                       .busy, .out(out_ch));
endmodule
`default_nettype wire
